@@ hw/rtl/interleaved_channel_averager_macros.svh @@
// ----------------------------------------------------------------------------
// Interleaved channel averager assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_CHANNEL_AVERAGER_MACROS_SVH
`define INTERLEAVED_CHANNEL_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ICA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ICA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/icavg_pkg.sv @@
// ----------------------------------------------------------------------------
// icavg_pkg
// Widths, register codes and shared types of the interleaved channel averager.
// ----------------------------------------------------------------------------
package icavg_pkg;

  localparam int NUM_CH      = 5;
  localparam int CH_W        = 3;
  localparam int SAMPLE_W    = 12;
  localparam int NARROW_W    = 8;
  localparam int IDX_W       = 13;
  localparam int RING_DEPTH  = 8192;
  localparam int RING_BITS   = $clog2(RING_DEPTH);
  localparam int MAX_AVERAGE = 256;
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 21;
  localparam int AVG_W       = 20;
  localparam int FRAC_BITS   = 8;
  localparam int SHIFT_W     = AVG_W - FRAC_BITS;
  localparam int ITER_W      = $clog2(AVG_W);
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_AVERAGE_COUNT = 2'd1;
  localparam logic [1:0] REG_WIDE_SAMPLES  = 2'd2;

  // Effective configuration after clamping
  typedef struct packed {
    logic [CH_W-1:0]  nch;
    logic [CNT_W-1:0] divisor;
    logic             wide;
  } cfg_t;

  // Classified sample as it travels from front to back
  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
    logic                is_final;
  } item_t;

endpackage

@@ hw/rtl/icavg_front.sv @@
// ----------------------------------------------------------------------------
// icavg_front
// Accepts samples, masks narrow samples and resolves the channel number.
// ----------------------------------------------------------------------------
module icavg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  icavg_pkg::cfg_t               cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [icavg_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic [icavg_pkg::IDX_W-1:0]    in_ring_index,
  input  logic                          in_final_sample,
  output logic                          push,
  output icavg_pkg::item_t              push_item,
  input  logic                          q_full
);
  import icavg_pkg::*;

  // 4 = 1 mod 3: fold base-4 digits
  function automatic logic [1:0] mod3(input logic [IDX_W-1:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s  = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8])
       + 5'(v[11:10]) + 5'(v[12]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : 2'(s3);
  endfunction

  // 16 = 1 mod 5: fold hex digits
  function automatic logic [2:0] mod5(input logic [IDX_W-1:0] v);
    logic [5:0] s;
    logic [4:0] s2;
    logic [4:0] r;
    s  = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[12]);
    s2 = 5'(s[3:0]) + 5'(s[5:4]);
    r  = (s2 >= 5'd10) ? (s2 - 5'd10) : s2;
    r  = (r >= 5'd5) ? (r - 5'd5) : r;
    return 3'(r);
  endfunction

  logic                 fv_r, fv_nxt;
  item_t                fitem_r;
  logic                 accept;
  logic [IDX_W-1:0]     pos;
  logic [CH_W-1:0]      ch;
  logic [SAMPLE_W-1:0]  sample;

  assign in_stall  = fv_r & q_full;
  assign accept    = in_valid & ~in_stall;
  assign push      = fv_r & ~q_full;
  assign push_item = fitem_r;

  assign pos    = IDX_W'(in_ring_index[RING_BITS-1:0]);
  assign sample = cfg.wide ? in_sample_value
                           : SAMPLE_W'(in_sample_value[NARROW_W-1:0]);

  always_comb begin
    unique case (cfg.nch)
      3'd1:    ch = '0;
      3'd2:    ch = CH_W'(pos[0]);
      3'd3:    ch = CH_W'(mod3(pos));
      3'd4:    ch = CH_W'(pos[1:0]);
      default: ch = mod5(pos);
    endcase
  end

  always_comb begin
    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fitem_r <= '{ch: ch, sample: sample, is_final: in_final_sample};
    end
  end

endmodule

@@ hw/rtl/icavg_queue.sv @@
// ----------------------------------------------------------------------------
// icavg_queue
// Two-entry queue that decouples classification from accumulation.
// ----------------------------------------------------------------------------
module icavg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  icavg_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output icavg_pkg::item_t pop_item
);
  import icavg_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/icavg_back.sv @@
// ----------------------------------------------------------------------------
// icavg_back
// Channel sums, and on a final sample one shared restoring divide per channel.
// ----------------------------------------------------------------------------
module icavg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  icavg_pkg::cfg_t                cfg,
  input  logic                           q_empty,
  input  icavg_pkg::item_t               pop_item,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [icavg_pkg::CH_W-1:0]     out_channel_number,
  output logic [icavg_pkg::AVG_W-1:0]    out_average_value,
  output logic                           out_overflowed,
  output logic                           out_last_channel
);
  import icavg_pkg::*;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [SUM_W-1:0]  sums_r [NUM_CH];
  logic [SUM_W-1:0]  sums_nxt [NUM_CH];
  logic [CH_W-1:0]   k_r, k_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [AVG_W-1:0]  qr_r, qr_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ov_r, ov_nxt;
  logic [CH_W-1:0]   och_r, och_nxt;
  logic [AVG_W-1:0]  oavg_r, oavg_nxt;
  logic              oovf_r, oovf_nxt;
  logic              olast_r, olast_nxt;

  logic [SUM_W:0]    add;
  logic [SUM_W-1:0]  sel;
  logic [CNT_W-1:0]  trial;
  logic              last_k;

  assign pop    = (state_r == ST_ACC) & ~q_empty;
  assign add    = (SUM_W+1)'(sums_r[pop_item.ch]) + (SUM_W+1)'(pop_item.sample);
  assign sel    = sums_r[k_r];
  assign trial  = {rem_r[CNT_W-2:0], qr_r[AVG_W-1]};
  assign last_k = (k_r == cfg.nch - CH_W'(1));

  assign out_valid          = ov_r;
  assign out_channel_number = och_r;
  assign out_average_value  = oavg_r;
  assign out_overflowed     = oovf_r;
  assign out_last_channel   = olast_r;

  always_comb begin
    state_nxt = state_r;
    sums_nxt  = sums_r;
    k_nxt     = k_r;
    iter_nxt  = iter_r;
    rem_nxt   = rem_r;
    qr_nxt    = qr_r;
    ovf_nxt   = ovf_r;
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    oavg_nxt  = oavg_r;
    oovf_nxt  = oovf_r;
    olast_nxt = olast_r;
    unique case (state_r)
      ST_ACC: begin
        if (pop) begin
          sums_nxt[pop_item.ch] = add[SUM_W] ? SUM_MAX : add[SUM_W-1:0];
          if (pop_item.is_final) begin
            k_nxt     = '0;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // Average saturates exactly when sum >= divisor * 2^SHIFT_W
        rem_nxt   = sel[SUM_W-1:SHIFT_W];
        qr_nxt    = {sel[SHIFT_W-1:0], FRAC_BITS'(0)};
        ovf_nxt   = (sel >= {cfg.divisor, SHIFT_W'(0)});
        iter_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (trial >= cfg.divisor) begin
          rem_nxt = trial - cfg.divisor;
          qr_nxt  = {qr_r[AVG_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          qr_nxt  = {qr_r[AVG_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(AVG_W - 1)) begin
          ov_nxt    = 1'b1;
          och_nxt   = k_r;
          oavg_nxt  = ovf_r ? AVG_MAX : qr_nxt;
          oovf_nxt  = ovf_r;
          olast_nxt = last_k;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (last_k) begin
            for (int i = 0; i < NUM_CH; i++) begin
              sums_nxt[i] = '0;
            end
            state_nxt = ST_ACC;
          end else begin
            k_nxt     = k_r + CH_W'(1);
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      ov_r    <= 1'b0;
      k_r     <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
      sums_r  <= sums_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r  <= iter_nxt;
    rem_r   <= rem_nxt;
    qr_r    <= qr_nxt;
    ovf_r   <= ovf_nxt;
    och_r   <= och_nxt;
    oavg_r  <= oavg_nxt;
    oovf_r  <= oovf_nxt;
    olast_r <= olast_nxt;
  end

endmodule

@@ hw/rtl/interleaved_channel_averager.sv @@
// ----------------------------------------------------------------------------
// interleaved_channel_averager
// Per-channel block averages of interleaved converter samples.
// ----------------------------------------------------------------------------
// Outside the drain, samples are accumulated at one per cycle: a front stage
// resolves the channel from the ring index and feeds a two-entry queue, and
// the back stage adds one queued sample per cycle into its channel sum
// (saturating at 21 bits). A sample marked final starts the drain: for each
// used channel the single restoring divider produces one quotient bit per
// cycle, and each result passes through one load, 20 divide steps and one
// output state, where an output stall can hold it. During the drain the
// front keeps taking samples until the queue and front register are full
// (three samples), then stalls. Configuration goes through the APB port at
// byte addresses 0, 4 and 8 and is read back as written.
// ----------------------------------------------------------------------------
module interleaved_channel_averager (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [icavg_pkg::ADDR_W-1:0]    paddr,
  input  logic [icavg_pkg::DATA_W-1:0]    pwdata,
  output logic [icavg_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [icavg_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [icavg_pkg::IDX_W-1:0]     in_ring_index,
  input  logic                            in_final_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [icavg_pkg::CH_W-1:0]      out_channel_number,
  output logic [icavg_pkg::AVG_W-1:0]     out_average_value,
  output logic                            out_overflowed,
  output logic                            out_last_channel
);
  import icavg_pkg::*;

  logic [CH_W-1:0]  chan_cnt_r;
  logic [CNT_W-1:0] avg_cnt_r;
  logic             wide_r;
  logic             wr_en;
  cfg_t             cfg;
  logic             push, q_full, pop, q_empty;
  item_t            push_item, pop_item;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= CH_W'(1);
      avg_cnt_r  <= CNT_W'(1);
      wide_r     <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CHANNEL_COUNT: chan_cnt_r <= pwdata[CH_W-1:0];
        REG_AVERAGE_COUNT: avg_cnt_r  <= pwdata[CNT_W-1:0];
        REG_WIDE_SAMPLES:  wide_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = DATA_W'(chan_cnt_r);
      REG_AVERAGE_COUNT: prdata = DATA_W'(avg_cnt_r);
      REG_WIDE_SAMPLES:  prdata = DATA_W'(wide_r);
      default:           prdata = '0;
    endcase
  end

  // Clamp counts into their legal ranges
  always_comb begin
    if (chan_cnt_r == '0) begin
      cfg.nch = CH_W'(1);
    end else if (chan_cnt_r > CH_W'(NUM_CH)) begin
      cfg.nch = CH_W'(NUM_CH);
    end else begin
      cfg.nch = chan_cnt_r;
    end
    if (avg_cnt_r == '0) begin
      cfg.divisor = CNT_W'(1);
    end else if (avg_cnt_r > CNT_W'(MAX_AVERAGE)) begin
      cfg.divisor = CNT_W'(MAX_AVERAGE);
    end else begin
      cfg.divisor = avg_cnt_r;
    end
    cfg.wide = wide_r;
  end

  icavg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .in_ring_index   (in_ring_index),
    .in_final_sample (in_final_sample),
    .push            (push),
    .push_item       (push_item),
    .q_full          (q_full)
  );

  icavg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  icavg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .pop_item           (pop_item),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_number (out_channel_number),
    .out_average_value  (out_average_value),
    .out_overflowed     (out_overflowed),
    .out_last_channel   (out_last_channel)
  );

endmodule

@@ hw/rtl/icavg_checker.sv @@
// ----------------------------------------------------------------------------
// icavg_checker
// Port-level checks on the result stream of the averager.
// ----------------------------------------------------------------------------
`include "interleaved_channel_averager_macros.svh"

module icavg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [icavg_pkg::CH_W-1:0]   out_channel_number,
  input logic [icavg_pkg::AVG_W-1:0]  out_average_value,
  input logic                         out_overflowed,
  input logic                         out_last_channel
);
  import icavg_pkg::*;

  logic [CH_W-1:0] exp_ch_r;
  logic            xfer;

  assign xfer = out_valid & ~out_stall;

  // Expected channel of the next result: restart at zero after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ch_r <= '0;
    end else if (xfer) begin
      exp_ch_r <= out_last_channel ? '0 : exp_ch_r + CH_W'(1);
    end
  end

  `ICA_ASSERT_IMP(a_ch_order, out_valid, out_channel_number == exp_ch_r, "channel out of order")
  `ICA_ASSERT_IMP(a_ch_range, out_valid, out_channel_number < CH_W'(NUM_CH), "channel beyond five")
  `ICA_ASSERT_IMP(a_sat_max, out_valid && out_overflowed, out_average_value == AVG_MAX, "overflow without saturation")
  `ICA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_average_value), "stalled result changed")

endmodule

bind interleaved_channel_averager icavg_checker u_icavg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_channel_number (out_channel_number),
  .out_average_value  (out_average_value),
  .out_overflowed     (out_overflowed),
  .out_last_channel   (out_last_channel)
);
